/* rtl/dcd_pkg.sv */
// Shared constants, register codes and inter-stage types for the dehaze block.
// No dependencies.
`default_nettype none
package dcd_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_ROWS   = 2 * MAX_RADIUS + 1;
  localparam int PIX_ROWS   = MAX_RADIUS + 1;
  localparam int TAPS       = 2 * MAX_RADIUS + 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 11;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int GAIN_W     = 10;
  localparam int S7_W       = $clog2(MIN_ROWS);
  localparam int S4_W       = $clog2(PIX_ROWS);
  localparam int CNT_W      = $clog2(MAX_RADIUS + 2);
  localparam int PIX_W      = 24;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_PGAIN  = 3'd3,
    REG_DGAIN  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [RAD_W-1:0]  r;
    logic [GAIN_W-1:0] pg;
    logic [GAIN_W-1:0] dg;
  } cfg_t;

  typedef struct packed {
    logic [TAPS-1:0][7:0]          cm;
    logic [PIX_ROWS-1:0][PIX_W-1:0] px;
    logic [RAD_W-1:0]              r;
    logic [RAD_W-1:0]              kstart;
    logic [CNT_W-1:0]              count;
    logic                          eof;
  } snap_t;
endpackage
`default_nettype wire

/* rtl/dark_channel_dehaze.sv */
// Top level of the dark channel dehaze block: config registers and stage wiring.
// Depends on dcd_pkg, dcd_window, dcd_emit (and dcd_ram below them).
//
//  channel | handshake            | payload
//  in_     | in_valid / in_ready  | in_action, in_channel0..2
//  out_    | out_valid/out_ready  | out_channel0..2, out_dark_value, out_end_of_frame,
//          |                      | out_last_of_run
//  cfg_    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One pixel request per clock while the output is not stalled. A row-end pixel causes up to radius+1 results,
// which leave one per cycle while out_ready is high; the input stalls for those extra cycles.
// Path: accept (line memory read, input register) -> sequencer -> output
// register.
// Reset (rst_n low, synchronous) clears counters and valid flags and loads the
// default registers; line memories are not cleared (never read before written).
// Output stalls back up through the sequencer and input register; nothing drops.
`default_nettype none
module dark_channel_dehaze
  import dcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_channel0,
  input  wire logic [7:0] in_channel1,
  input  wire logic [7:0] in_channel2,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_channel0,
  output logic [7:0]      out_channel1,
  output logic [7:0]      out_channel2,
  output logic [7:0]      out_dark_value,
  output logic            out_end_of_frame,
  output logic            out_last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [10:0] cfg_data
);
  logic [DIM_W-1:0]  width_r, height_r;
  logic [1:0]        radius_r;
  logic [GAIN_W-1:0] pgain_r, dgain_r;
  cfg_t              cfg;
  logic              snap_valid, snap_ready;
  snap_t             snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      radius_r <= 2'd1;
      pgain_r  <= GAIN_W'(346);   // 1.35 in Q2.8
      dgain_r  <= GAIN_W'(218);   // 0.85 in Q2.8
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[1:0];
        REG_PGAIN:  pgain_r  <= cfg_data[GAIN_W-1:0];
        REG_DGAIN:  dgain_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective values: zero counts as one, oversize clamps to the maximum
  always_comb begin
    cfg.w  = (width_r == '0) ? DIM_W'(1)
           : (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
    cfg.h  = (height_r == '0) ? DIM_W'(1)
           : (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;
    cfg.r  = (radius_r > 2'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);
    cfg.pg = pgain_r;
    cfg.dg = dgain_r;
  end

  dcd_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_channel0 (in_channel0),
    .in_channel1 (in_channel1),
    .in_channel2 (in_channel2),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap)
  );

  dcd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .pg               (cfg.pg),
    .dg               (cfg.dg),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel0     (out_channel0),
    .out_channel1     (out_channel1),
    .out_channel2     (out_channel2),
    .out_dark_value   (out_dark_value),
    .out_end_of_frame (out_end_of_frame),
    .out_last_of_run  (out_last_of_run)
  );
endmodule
`default_nettype wire

/* rtl/dcd_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module dcd_ram #(
  parameter int DW = 8,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* rtl/dcd_window.sv */
// Input stage: raster counters, line memories, column-min and pixel tap shift.
// Depends on dcd_pkg and dcd_ram.
`default_nettype none
module dcd_window
  import dcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_channel0,
  input  wire logic [7:0] in_channel1,
  input  wire logic [7:0] in_channel2,
  output logic            snap_valid,
  input  wire logic       snap_ready,
  output snap_t           snap
);
  logic             acc;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [S7_W-1:0]  slot7_r;
  logic [S4_W-1:0]  slot4_r;
  logic [7:0]       c0, c1, c2, mn;
  logic             row_end, cv, row_wrap;
  logic [S4_W-1:0]  rslot;
  logic [CNT_W-1:0] n0;
  logic [RAD_W-1:0] k0;
  logic             eof0;

  logic                   s1_valid_r;
  logic [PIX_W-1:0]       s1_pix_r;
  logic [7:0]             s1_mn_r;
  logic [ROW_W-1:0]       s1_row_r;
  logic [COL_W-1:0]       s1_col_r;
  logic [S7_W-1:0]        s1_slot7_r;
  logic [CNT_W-1:0]       s1_n_r;
  logic [RAD_W-1:0]       s1_k_r;
  logic                   s1_eof_r;
  logic                   s1_adv;

  logic [MIN_ROWS-1:0][7:0] rd_min;
  logic [PIX_W-1:0]         rd_pix;
  logic [7:0]               vm;
  logic [TAPS-1:0][7:0]     cm_nxt;
  logic [PIX_ROWS-1:0][PIX_W-1:0] px_nxt;
  logic [TAPS-2:0][7:0]     cm_r;
  logic [PIX_ROWS-2:0][PIX_W-1:0] px_r;

  assign acc = in_valid & in_ready;
  assign c0  = in_action ? 8'hFF : in_channel0;
  assign c1  = in_action ? 8'hFF : in_channel1;
  assign c2  = in_action ? 8'hFF : in_channel2;

  always_comb begin
    mn = (c0 < c1) ? c0 : c1;
    if (c2 < mn) mn = c2;
  end

  assign row_end  = {1'b0, col_r} >= (cfg.w - 1'b1);
  assign row_wrap = row_r >= (cfg.h - 1'b1 + ROW_W'(cfg.r));
  assign cv       = (row_r >= ROW_W'(cfg.r)) && ((row_r - ROW_W'(cfg.r)) < cfg.h);
  assign rslot    = (slot4_r >= S4_W'(cfg.r)) ? S4_W'(slot4_r - S4_W'(cfg.r))
                  : S4_W'((S4_W+1)'(slot4_r) + (S4_W+1)'(PIX_ROWS) - (S4_W+1)'(cfg.r));

  // results caused by this item: centre taps k0 down to 0 at a row end
  always_comb begin
    n0   = '0;
    k0   = cfg.r;
    eof0 = 1'b0;
    if (cv) begin
      if (row_end) begin
        k0   = (col_r < COL_W'(cfg.r)) ? RAD_W'(col_r) : cfg.r;
        n0   = CNT_W'(k0) + 1'b1;
        eof0 = ((row_r - ROW_W'(cfg.r)) == (cfg.h - 1'b1)) && ({1'b0, col_r} == (cfg.w - 1'b1));
      end else if (col_r >= COL_W'(cfg.r)) begin
        n0 = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      slot7_r <= '0;
      slot4_r <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_r <= '0;
        if (row_wrap) begin
          row_r   <= '0;
          slot7_r <= '0;
          slot4_r <= '0;
        end else begin
          row_r   <= row_r + 1'b1;
          slot7_r <= (slot7_r == S7_W'(MIN_ROWS - 1)) ? '0 : slot7_r + 1'b1;
          slot4_r <= (slot4_r == S4_W'(PIX_ROWS - 1)) ? '0 : slot4_r + 1'b1;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  for (genvar m = 0; m < MIN_ROWS; m++) begin : g_min
    dcd_ram #(.DW(8), .AW(COL_W)) u_min (
      .clk   (clk),
      .we    (acc && (slot7_r == S7_W'(m))),
      .waddr (col_r),
      .wdata (mn),
      .re    (acc),
      .raddr (col_r),
      .rdata (rd_min[m])
    );
  end

  dcd_ram #(.DW(PIX_W), .AW(S4_W + COL_W)) u_pix (
    .clk   (clk),
    .we    (acc),
    .waddr ({slot4_r, col_r}),
    .wdata ({c2, c1, c0}),
    .re    (acc),
    .raddr ({rslot, col_r}),
    .rdata (rd_pix)
  );

  assign s1_adv     = s1_valid_r && ((s1_n_r == '0) || snap_ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign snap_valid = s1_valid_r && (s1_n_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= {c2, c1, c0};
      s1_mn_r    <= mn;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_slot7_r <= slot7_r;
      s1_n_r     <= n0;
      s1_k_r     <= k0;
      s1_eof_r   <= eof0;
    end
  end

  // vertical minimum over rows row-2R..row, rows outside the image read 255
  always_comb begin
    logic [S7_W:0]  diff;
    logic [S7_W-1:0] d;
    vm = (s1_row_r < cfg.h) ? s1_mn_r : 8'hFF;
    for (int m = 0; m < MIN_ROWS; m++) begin
      diff = (S7_W+1)'(s1_slot7_r) + (S7_W+1)'(MIN_ROWS) - (S7_W+1)'(m);
      if (diff >= (S7_W+1)'(MIN_ROWS)) diff = diff - (S7_W+1)'(MIN_ROWS);
      d = diff[S7_W-1:0];
      if ((d != '0) && ((S7_W+1)'(d) <= {cfg.r, 1'b0}) && (s1_row_r >= ROW_W'(d))
          && ((s1_row_r - ROW_W'(d)) < cfg.h) && (rd_min[m] < vm)) begin
        vm = rd_min[m];
      end
    end
  end

  always_comb begin
    cm_nxt[0] = vm;
    for (int j = 1; j < TAPS; j++) begin
      cm_nxt[j] = (s1_col_r < COL_W'(j)) ? 8'hFF : cm_r[j-1];
    end
    px_nxt[0] = (cfg.r == '0) ? s1_pix_r : rd_pix;
    for (int j = 1; j < PIX_ROWS; j++) begin
      px_nxt[j] = px_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      cm_r <= cm_nxt[TAPS-2:0];
      px_r <= px_nxt[PIX_ROWS-2:0];
    end
  end

  always_comb begin
    snap.cm     = cm_nxt;
    snap.px     = px_nxt;
    snap.r      = cfg.r;
    snap.kstart = s1_k_r;
    snap.count  = s1_n_r;
    snap.eof    = s1_eof_r;
  end
endmodule
`default_nettype wire

/* rtl/dcd_emit.sv */
// Result sequencer: horizontal window minimum, gain arithmetic, output register.
// Depends on dcd_pkg.
`default_nettype none
module dcd_emit
  import dcd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [GAIN_W-1:0] pg,
  input  wire logic [GAIN_W-1:0] dg,
  input  wire logic            snap_valid,
  output logic                 snap_ready,
  input  wire snap_t           snap,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_channel0,
  output logic [7:0]           out_channel1,
  output logic [7:0]           out_channel2,
  output logic [7:0]           out_dark_value,
  output logic                 out_end_of_frame,
  output logic                 out_last_of_run
);
  logic             busy_r;
  snap_t            sn_r;
  logic [RAD_W-1:0] k_r;
  logic [CNT_W-1:0] left_r;
  logic             load_out, fire, take;
  logic [7:0]       dark;
  logic [7:0]       q0, q1, q2;
  logic [PIX_W-1:0] pix;

  assign load_out   = !out_valid || out_ready;
  assign fire       = busy_r && load_out;
  assign snap_ready = !busy_r || (fire && (left_r == CNT_W'(1)));
  assign take       = snap_valid && snap_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (take) begin
      busy_r <= 1'b1;
    end else if (fire && (left_r == CNT_W'(1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sn_r   <= snap;
      k_r    <= snap.kstart;
      left_r <= snap.count;
    end else if (fire) begin
      k_r    <= k_r - 1'b1;
      left_r <= left_r - 1'b1;
    end
  end

  // window over taps k-R..k+R; taps past the row end were never shifted in
  always_comb begin
    dark = 8'hFF;
    for (int j = 0; j < TAPS; j++) begin
      if (((RAD_W+2)'(j) + (RAD_W+2)'(sn_r.r) >= (RAD_W+2)'(k_r))
          && ((RAD_W+2)'(j) <= (RAD_W+2)'(k_r) + (RAD_W+2)'(sn_r.r))
          && (sn_r.cm[j] < dark)) begin
        dark = sn_r.cm[j];
      end
    end
  end

  assign pix = sn_r.px[k_r];

  function automatic logic [7:0] dehaze(input logic [7:0] ch, input logic [7:0] dk,
                                        input logic [GAIN_W-1:0] gp,
                                        input logic [GAIN_W-1:0] gd);
    logic [GAIN_W+7:0] a, b, v;
    a = ch * gp;
    b = dk * gd;
    v = a - b;
    if (a <= b) return 8'd0;
    if (v[GAIN_W+7:8] > 255) return 8'hFF;
    return v[15:8];
  endfunction

  assign q0 = dehaze(pix[7:0], dark, pg, dg);
  assign q1 = dehaze(pix[15:8], dark, pg, dg);
  assign q2 = dehaze(pix[23:16], dark, pg, dg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_channel0     <= q0;
      out_channel1     <= q1;
      out_channel2     <= q2;
      out_dark_value   <= dark;
      out_end_of_frame <= sn_r.eof && (k_r == '0);
      out_last_of_run  <= (left_r == CNT_W'(1));
    end
  end
endmodule
`default_nettype wire

/* rtl/dcd_checker.sv */
// Port-level checks for dark_channel_dehaze, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module dcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_channel0,
  input wire logic [7:0] out_dark_value,
  input wire logic       out_end_of_frame,
  input wire logic       out_last_of_run,
  input wire logic       cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel0)
      && $stable(out_dark_value))
    else $error("stalled result changed");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_run)
    else $error("frame end not last of run");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
endmodule

bind dark_channel_dehaze dcd_checker u_dcd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_channel0     (out_channel0),
  .out_dark_value   (out_dark_value),
  .out_end_of_frame (out_end_of_frame),
  .out_last_of_run  (out_last_of_run),
  .cfg_ready        (cfg_ready)
);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for dark_channel_dehaze: whole frames of random pixels under
// random settings, checked against an in-bench dehaze predictor. Needs rtl/dcd_pkg.sv.
module testbench;
  import dcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       flush;
    logic [7:0] ch0, ch1, ch2;
  } pixel_req_t;

  typedef struct {
    logic [7:0] ch0, ch1, ch2, dark;
    logic       eof, last;
  } dehazed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [7:0]  in_channel0 = '0, in_channel1 = '0, in_channel2 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_channel0, out_channel1, out_channel2, out_dark_value;
  logic        out_end_of_frame, out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  dark_channel_dehaze u_dut (.*);

  initial forever #2 clk = ~clk;

  // Shadow of the block: registers, line stores and raster position.
  logic [10:0] sh_width, sh_height;
  logic [1:0]  sh_radius;
  logic [9:0]  sh_pgain, sh_dgain;
  logic [7:0]  min_rows [MIN_ROWS][MAX_WIDTH];
  logic [23:0] pix_rows [PIX_ROWS][MAX_WIDTH];
  int          pos_row, pos_col;

  pixel_req_t  pixel_q[$];     // requests waiting for the driver
  dehazed_t    dehazed_q[$];   // predicted results, oldest first
  int          errors = 0;
  int          accepted_px = 0;
  bit          fast_mode = 0;  // no input gaps while set

  function automatic int eff_w();
    return sh_width == 0 ? 1 : (sh_width > MAX_WIDTH ? MAX_WIDTH : int'(sh_width));
  endfunction
  function automatic int eff_h();
    return sh_height == 0 ? 1 : (sh_height > MAX_HEIGHT ? MAX_HEIGHT : int'(sh_height));
  endfunction
  function automatic int eff_r();
    return sh_radius > MAX_RADIUS ? MAX_RADIUS : int'(sh_radius);
  endfunction

  function automatic logic [7:0] dehaze_ch(logic [7:0] ch, logic [7:0] dark);
    int v;
    v = int'(ch) * int'(sh_pgain) - int'(dark) * int'(sh_dgain);
    if (v <= 0) return 8'd0;
    v = v >>> 8;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  // Padded window minimum over the stored channel minima.
  function automatic logic [7:0] dark_at(int cr, int c, int r, int w, int h);
    logic [7:0] lo;
    int rr, cc;
    lo = 8'd255;
    for (rr = cr - r; rr <= cr + r; rr++) begin
      if (rr < 0 || rr >= h) continue;
      for (cc = c - r; cc <= c + r; cc++) begin
        if (cc < 0 || cc >= w) continue;
        if (min_rows[rr % MIN_ROWS][cc] < lo) lo = min_rows[rr % MIN_ROWS][cc];
      end
    end
    return lo;
  endfunction

  // Advance the shadow by one accepted pixel and queue whatever it emits.
  function automatic void predict_dehaze(pixel_req_t p);
    int w, h, r, cr, first, last, c, n;
    logic [7:0] a, b, d, mn;
    logic [23:0] px;
    dehazed_t e;
    w = eff_w(); h = eff_h(); r = eff_r();
    cr = pos_row - r;
    n = 0;
    if (p.flush) begin
      a = 8'd255; b = 8'd255; d = 8'd255;
    end else begin
      a = p.ch0; b = p.ch1; d = p.ch2;
    end
    mn = a < b ? a : b;
    if (d < mn) mn = d;
    min_rows[pos_row % MIN_ROWS][pos_col] = mn;
    pix_rows[pos_row % PIX_ROWS][pos_col] = {d, b, a};
    if (cr >= 0 && cr < h) begin
      if (pos_col >= w - 1) begin
        first = (w - 1 - r) < 0 ? 0 : w - 1 - r;
        last = w - 1;
      end else begin
        first = pos_col - r;
        last = first;
      end
      for (c = first; c <= last; c++) begin
        if (c < 0) continue;
        px = pix_rows[cr % PIX_ROWS][c];
        e.dark = dark_at(cr, c, r, w, h);
        e.ch0 = dehaze_ch(px[7:0], e.dark);
        e.ch1 = dehaze_ch(px[15:8], e.dark);
        e.ch2 = dehaze_ch(px[23:16], e.dark);
        e.eof = (cr == h - 1 && c == w - 1);
        e.last = 1'b0;
        dehazed_q.push_back(e);
        n++;
      end
      if (n > 0) dehazed_q[$].last = 1'b1;
    end
    if (pos_col >= w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= h - 1 + r) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    if (fast_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
  endfunction

  // Driver: one request per accept, payload held until taken.
  int gap_left = 0;
  always @(posedge clk) begin
    pixel_req_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        nxt.flush = in_action;
        nxt.ch0 = in_channel0; nxt.ch1 = in_channel1; nxt.ch2 = in_channel2;
        predict_dehaze(nxt);
        accepted_px++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          in_action   <= nxt.flush;
          in_channel0 <= nxt.ch0;
          in_channel1 <= nxt.ch1;
          in_channel2 <= nxt.ch2;
          in_valid    <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every taken result, randomize ready, one long hold-off.
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    dehazed_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (dehazed_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = dehazed_q.pop_front();
          if (out_channel0 !== e.ch0) begin
            $error("out_channel0 exp %0d got %0d", e.ch0, out_channel0); errors++;
          end
          if (out_channel1 !== e.ch1) begin
            $error("out_channel1 exp %0d got %0d", e.ch1, out_channel1); errors++;
          end
          if (out_channel2 !== e.ch2) begin
            $error("out_channel2 exp %0d got %0d", e.ch2, out_channel2); errors++;
          end
          if (out_dark_value !== e.dark) begin
            $error("out_dark_value exp %0d got %0d", e.dark, out_dark_value); errors++;
          end
          if (out_end_of_frame !== e.eof) begin
            $error("out_end_of_frame exp %0d got %0d", e.eof, out_end_of_frame); errors++;
          end
          if (out_last_of_run !== e.last) begin
            $error("out_last_of_run exp %0d got %0d", e.last, out_last_of_run); errors++;
          end
        end
      end
      // the long hold-off lets the pipe fill and back-pressure the input
      if (!hold_done && accepted_px >= 300) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (fast_mode) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        hold_left = $urandom_range(10, 50);
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 3) != 0;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [10:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  sh_width  = val;
      REG_HEIGHT: sh_height = val;
      REG_RADIUS: sh_radius = val[1:0];
      REG_PGAIN:  sh_pgain  = val[9:0];
      REG_DGAIN:  sh_dgain  = val[9:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Block must be drained before any register changes.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || dehazed_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup(logic [10:0] w, logic [10:0] h, logic [1:0] r,
                       logic [9:0] pg, logic [9:0] dg);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, {9'd0, r});
    write_reg(REG_PGAIN, {1'b0, pg});
    write_reg(REG_DGAIN, {1'b0, dg});
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Whole frame plus bottom flush; noise_pct of pixels become flushes.
  task automatic queue_frame(int noise_pct);
    pixel_req_t p;
    int i, real_n, total;
    real_n = eff_w() * eff_h();
    total = (eff_h() + eff_r()) * eff_w();
    for (i = 0; i < total; i++) begin
      p.ch0 = pick_chan(); p.ch1 = pick_chan(); p.ch2 = pick_chan();
      p.flush = (i >= real_n) || ($urandom_range(0, 99) < noise_pct);
      pixel_q.push_back(p);
    end
  endtask

  task automatic push_px(logic f, logic [7:0] a, logic [7:0] b, logic [7:0] d);
    pixel_req_t p;
    p.flush = f; p.ch0 = a; p.ch1 = b; p.ch2 = d;
    pixel_q.push_back(p);
  endtask

  initial begin
    int rnd_items;
    logic [10:0] w, h;
    sh_width = 11'd640; sh_height = 11'd480; sh_radius = 2'd1;
    sh_pgain = 10'd346; sh_dgain = 10'd218;
    pos_row = 0; pos_col = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x2 frame at default gains with extremes and a mid-frame flush.
    setup(11'd3, 11'd2, 2'd1, 10'd346, 10'd218);
    push_px(1'b0, 8'd0, 8'd0, 8'd0);
    push_px(1'b0, 8'd255, 8'd255, 8'd255);
    push_px(1'b1, 8'd12, 8'd34, 8'd56);
    push_px(1'b0, 8'd255, 8'd0, 8'd128);
    push_px(1'b0, 8'd200, 8'd220, 8'd240);
    push_px(1'b0, 8'd1, 8'd254, 8'd77);
    repeat (3) push_px(1'b1, 8'd0, 8'd0, 8'd0);
    // one-pixel row, widest radius: every result comes from a row end
    setup(11'd1, 11'd1, 2'd3, 10'd1023, 10'd0);
    push_px(1'b0, 8'd255, 8'd128, 8'd1);
    repeat (3) push_px(1'b1, 8'd0, 8'd0, 8'd0);
    // zero width/height clamp to one, pixel gain zero, dark gain at its maximum
    setup(11'd0, 11'd0, 2'd0, 10'd0, 10'd1023);
    push_px(1'b0, 8'd255, 8'd255, 8'd255);

    // Random frames: mostly small, sometimes with flush noise and no gaps.
    rnd_items = 0;
    while (rnd_items < 500) begin
      w = $urandom_range(0, 7) == 0 ? 11'($urandom_range(0, 40)) : 11'($urandom_range(1, 10));
      h = 11'($urandom_range(1, 6));
      setup(w, h, 2'($urandom_range(0, 3)),
            $urandom_range(0, 3) == 0 ? 10'd1023 : 10'($urandom_range(0, 1023)),
            $urandom_range(0, 3) == 0 ? 10'd0 : 10'($urandom_range(0, 1023)));
      fast_mode = $urandom_range(0, 4) == 0;
      queue_frame($urandom_range(0, 3) == 0 ? 20 : 0);
      rnd_items += (eff_h() + eff_r()) * eff_w();
    end
    wait_idle();
    fast_mode = 0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
